### hdl/imhq_pkg.sv
package imhq_pkg;

  localparam int NODE_COUNT  = 1024;
  localparam int NODE_BITS   = $clog2(NODE_COUNT);
  localparam int COUNT_BITS  = NODE_BITS + 1;
  localparam int METRIC_BITS = 32;
  localparam int POS_BITS    = NODE_BITS + 2;

  // Position table codes; any other value is a heap slot index.
  localparam logic [POS_BITS-1:0] POS_ABSENT = {POS_BITS{1'b1}};
  localparam logic [POS_BITS-1:0] POS_DONE   = {{(POS_BITS-1){1'b1}}, 1'b0};

  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_UPDATED   = 3'd1;
  localparam logic [2:0] ST_IGNORED   = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_EXTRACTED = 3'd4;
  localparam logic [2:0] ST_EMPTY     = 3'd5;

  typedef struct packed {
    logic                   operation;
    logic [NODE_BITS-1:0]   node_id;
    logic [METRIC_BITS-1:0] carried_metric;
    logic [METRIC_BITS-1:0] order_key;
  } in_item_t;

  typedef struct packed {
    logic [2:0]             status;
    logic [NODE_BITS-1:0]   out_node;
    logic [METRIC_BITS-1:0] out_carried_metric;
    logic [METRIC_BITS-1:0] out_order_key;
  } out_item_t;

  typedef struct packed {
    logic [NODE_BITS-1:0]   node;
    logic [METRIC_BITS-1:0] carried;
    logic [METRIC_BITS-1:0] key;
  } slot_t;

endpackage

### hdl/indexed_min_heap_queue.sv
// Full and empty answers arrive in the cycle after the transfer. An insert sifts up via
// S_UPGO and S_UPRD per level; an update does the same or sifts down via S_DNGO, S_DNL,
// S_DNR (right child only) and S_DNDEC per level. An extract sifts down up to nine levels.
// One item is worked on at a time; busy stays high until its result has been issued.
// Synchronous active-low reset, followed by a clearing pass that marks every node absent.
// The receiver cannot stall: each result is shown for one cycle with out_strobe.
module indexed_min_heap_queue
  import imhq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_item
);

  // Controller states. The heap keeps a "hole": the moving entry lives in cur_r and is
  // only written to its slot once its final place is known, which saves half the writes
  // of a plain swap.
  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_POS    = 4'd2;
  localparam logic [3:0] S_UPD    = 4'd3;
  localparam logic [3:0] S_UPGO   = 4'd4;
  localparam logic [3:0] S_UPRD   = 4'd5;
  localparam logic [3:0] S_DNGO   = 4'd6;
  localparam logic [3:0] S_DNL    = 4'd7;
  localparam logic [3:0] S_DNR    = 4'd8;
  localparam logic [3:0] S_DNDEC  = 4'd9;
  localparam logic [3:0] S_EXROOT = 4'd10;
  localparam logic [3:0] S_EXLAST = 4'd11;

  logic [3:0]            state_r, state_nxt;
  logic [NODE_BITS-1:0]  clr_r, clr_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [NODE_BITS-1:0]  idx_r, idx_nxt;
  slot_t                 cur_r, cur_nxt;
  slot_t                 best_r, best_nxt;
  logic [NODE_BITS-1:0]  best_idx_r, best_idx_nxt;
  logic                  best_vld_r, best_vld_nxt;
  slot_t                 ext_r, ext_nxt;
  logic [2:0]            st_r, st_nxt;
  logic                  out_strobe_r, out_strobe_nxt;
  out_item_t             out_r, out_nxt;

  // Slot memory: node, carried metric and key per heap slot.
  logic                 s_we;
  logic [NODE_BITS-1:0] s_wa, s_ra;
  slot_t                s_wd, s_rd;

  // Position table: per node, absent, done or its slot.
  logic                 p_we;
  logic [NODE_BITS-1:0] p_wa, p_ra;
  logic [POS_BITS-1:0]  p_wd, p_rd;

  imhq_ram #(.WIDTH($bits(slot_t)), .ADDR_BITS(NODE_BITS)) u_slot_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_wa),
    .wdata (s_wd),
    .raddr (s_ra),
    .rdata (s_rd)
  );

  imhq_ram #(.WIDTH(POS_BITS), .ADDR_BITS(NODE_BITS)) u_pos_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_wa),
    .wdata (p_wd),
    .raddr (p_ra),
    .rdata (p_rd)
  );

  // Child and parent indices of the current hole, with room for the overflow bits.
  logic [NODE_BITS+1:0] left_w, right_w, count_w;
  logic [NODE_BITS-1:0] parent_w;
  logic                 emit;
  logic [2:0]           em_status;

  assign left_w   = {1'b0, idx_r, 1'b1};
  assign right_w  = left_w + (NODE_BITS+2)'(1);
  assign count_w  = {1'b0, count_r};
  assign parent_w = (idx_r - NODE_BITS'(1)) >> 1;

  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    cur_nxt      = cur_r;
    best_nxt     = best_r;
    best_idx_nxt = best_idx_r;
    best_vld_nxt = best_vld_r;
    ext_nxt      = ext_r;
    st_nxt       = st_r;
    emit         = 1'b0;
    em_status    = st_r;
    s_we         = 1'b0;
    s_wa         = idx_r;
    s_wd         = cur_r;
    s_ra         = idx_r;
    p_we         = 1'b0;
    p_wa         = cur_r.node;
    p_wd         = {2'b00, idx_r};
    p_ra         = in_item.node_id;

    unique case (state_r)
      S_CLEAR: begin
        p_we = 1'b1;
        p_wa = clr_r;
        p_wd = POS_ABSENT;
        clr_nxt = clr_r + NODE_BITS'(1);
        if (clr_r == NODE_BITS'(NODE_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cur_nxt = '{node: in_item.node_id, carried: in_item.carried_metric,
                      key: in_item.order_key};
          if (in_item.operation == OP_EXTRACT) begin
            if (count_r == '0) begin
              emit      = 1'b1;
              em_status = ST_EMPTY;
            end else begin
              s_ra      = '0;
              st_nxt    = ST_EXTRACTED;
              state_nxt = S_EXROOT;
            end
          end else if (count_r == COUNT_BITS'(NODE_COUNT)) begin
            emit      = 1'b1;
            em_status = ST_FULL;
          end else begin
            state_nxt = S_POS;
          end
        end
      end
      S_POS: begin
        if (p_rd == POS_DONE) begin
          emit      = 1'b1;
          em_status = ST_IGNORED;
          state_nxt = S_IDLE;
        end else if (p_rd == POS_ABSENT || p_rd >= {1'b0, count_r}) begin
          // New node: it opens a hole at the end of the heap.
          idx_nxt   = count_r[NODE_BITS-1:0];
          count_nxt = count_r + COUNT_BITS'(1);
          st_nxt    = ST_INSERTED;
          state_nxt = S_UPGO;
        end else begin
          idx_nxt   = p_rd[NODE_BITS-1:0];
          s_ra      = p_rd[NODE_BITS-1:0];
          st_nxt    = ST_UPDATED;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        // A risen key cannot move up, a fallen one cannot move down.
        state_nxt = (cur_r.key > s_rd.key) ? S_DNGO : S_UPGO;
      end
      S_UPGO: begin
        if (idx_r == '0) begin
          s_we      = 1'b1;
          p_we      = 1'b1;
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          s_ra      = parent_w;
          state_nxt = S_UPRD;
        end
      end
      S_UPRD: begin
        if (s_rd.key > cur_r.key) begin
          // The parent moves down into the hole.
          s_we      = 1'b1;
          s_wd      = s_rd;
          p_we      = 1'b1;
          p_wa      = s_rd.node;
          idx_nxt   = parent_w;
          state_nxt = S_UPGO;
        end else begin
          s_we      = 1'b1;
          p_we      = 1'b1;
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_DNGO: begin
        if (left_w < count_w) begin
          s_ra      = left_w[NODE_BITS-1:0];
          state_nxt = S_DNL;
        end else begin
          s_we      = 1'b1;
          p_we      = 1'b1;
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_DNL: begin
        best_vld_nxt = s_rd.key < cur_r.key;
        best_nxt     = s_rd;
        best_idx_nxt = left_w[NODE_BITS-1:0];
        if (right_w < count_w) begin
          s_ra      = right_w[NODE_BITS-1:0];
          state_nxt = S_DNR;
        end else begin
          state_nxt = S_DNDEC;
        end
      end
      S_DNR: begin
        if (s_rd.key < (best_vld_r ? best_r.key : cur_r.key)) begin
          best_vld_nxt = 1'b1;
          best_nxt     = s_rd;
          best_idx_nxt = right_w[NODE_BITS-1:0];
        end
        state_nxt = S_DNDEC;
      end
      S_DNDEC: begin
        s_we = 1'b1;
        p_we = 1'b1;
        if (best_vld_r) begin
          // The smaller child moves up into the hole.
          s_wd      = best_r;
          p_wa      = best_r.node;
          idx_nxt   = best_idx_r;
          state_nxt = S_DNGO;
        end else begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_EXROOT: begin
        ext_nxt   = s_rd;
        p_we      = 1'b1;
        p_wa      = s_rd.node;
        p_wd      = POS_DONE;
        count_nxt = count_r - COUNT_BITS'(1);
        if (count_nxt == '0) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          s_ra      = count_nxt[NODE_BITS-1:0];
          state_nxt = S_EXLAST;
        end
      end
      S_EXLAST: begin
        // The last entry fills the root hole and sinks from there.
        cur_nxt   = s_rd;
        idx_nxt   = '0;
        state_nxt = S_DNGO;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_strobe_nxt = emit;
    out_nxt        = out_r;
    if (emit) begin
      out_nxt.status = em_status;
      if (em_status == ST_EXTRACTED) begin
        out_nxt.out_node           = ext_nxt.node;
        out_nxt.out_carried_metric = ext_nxt.carried;
        out_nxt.out_order_key      = ext_nxt.key;
      end else begin
        out_nxt.out_node           = '0;
        out_nxt.out_carried_metric = '0;
        out_nxt.out_order_key      = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      count_r      <= count_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    cur_r      <= cur_nxt;
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
    best_vld_r <= best_vld_nxt;
    ext_r      <= ext_nxt;
    st_r       <= st_nxt;
    out_r      <= out_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;

endmodule

### hdl/imhq_ram.sv
module imhq_ram #(
  parameter int WIDTH     = 8,
  parameter int ADDR_BITS = 4
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
